[hw/rtl/btt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Bracket tag tokenizer package
// Shared types, event and error codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package btt_pkg;

  localparam int unsigned LineW   = 24;
  localparam int unsigned ValLenW = 16;

  localparam logic [2:0] EvName   = 3'd0;
  localparam logic [2:0] EvKey    = 3'd1;
  localparam logic [2:0] EvValue  = 3'd2;
  localparam logic [2:0] EvProp   = 3'd3;
  localparam logic [2:0] EvTag    = 3'd4;
  localparam logic [2:0] EvAccept = 3'd5;
  localparam logic [2:0] EvError  = 3'd6;

  localparam logic [2:0] ErChar  = 3'd0;
  localparam logic [2:0] ErName  = 3'd1;
  localparam logic [2:0] ErProps = 3'd2;
  localparam logic [2:0] ErKey   = 3'd3;
  localparam logic [2:0] ErValue = 3'd4;
  localparam logic [2:0] ErEof   = 3'd5;

  localparam logic [1:0] CfgTagName  = 2'd0;
  localparam logic [1:0] CfgKeyName  = 2'd1;
  localparam logic [1:0] CfgValue    = 2'd2;
  localparam logic [1:0] CfgProperty = 2'd3;

  localparam logic [7:0]         TagNameMax  = 8'd128;
  localparam logic [7:0]         KeyNameMax  = 8'd128;
  localparam logic [ValLenW-1:0] PropValueMax = 16'd4096;
  localparam logic [7:0]         PropertyMax = 8'd128;

  localparam int unsigned FifoDepth = 3;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef struct packed {
    logic [7:0]         tag_name_limit;
    logic [7:0]         key_name_limit;
    logic [ValLenW-1:0] value_limit;
    logic [7:0]         property_limit;
  } cfg_t;

  typedef struct packed {
    logic [2:0]       event_kind;
    logic [7:0]       byte_out;
    logic [7:0]       prop_slot;
    logic [7:0]       prop_total;
    logic [LineW-1:0] line_no;
    logic [2:0]       error_code;
    logic             last_of_run;
  } res_t;

endpackage
`default_nettype wire

[hw/rtl/btt_doc_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Document byte channel
// Carries one document byte or an end-of-document marker per transaction.
// ----------------------------------------------------------------------------
interface btt_doc_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_doc;

  modport source (output valid, byte_in, end_of_doc, input ready);
  modport sink (input valid, byte_in, end_of_doc, output ready);
endinterface
`default_nettype wire

[hw/rtl/btt_evt_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Token event channel
// Carries one tokenizer event per transaction.
// ----------------------------------------------------------------------------
interface btt_evt_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [7:0]  byte_out;
  logic [7:0]  prop_slot;
  logic [7:0]  prop_total;
  logic [23:0] line_no;
  logic [2:0]  error_code;
  logic        last_of_run;

  modport source (output valid, event_kind, byte_out, prop_slot, prop_total, line_no,
                  error_code, last_of_run, input ready);
  modport sink (input valid, event_kind, byte_out, prop_slot, prop_total, line_no,
                error_code, last_of_run, output ready);
endinterface
`default_nettype wire

[hw/rtl/btt_cfg_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries a register index and write data per transaction.
// ----------------------------------------------------------------------------
interface btt_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/btt_cfg_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the four limit registers, written one transaction per cycle.
// ----------------------------------------------------------------------------
module btt_cfg_regs import btt_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        wr_valid_i,
  input  wire logic [1:0]  wr_index_i,
  input  wire logic [15:0] wr_data_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_valid_i) begin
      case (wr_index_i)
        CfgTagName:  cfg_d.tag_name_limit = wr_data_i[7:0];
        CfgKeyName:  cfg_d.key_name_limit = wr_data_i[7:0];
        CfgValue:    cfg_d.value_limit    = wr_data_i[ValLenW-1:0];
        CfgProperty: cfg_d.property_limit = wr_data_i[7:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tag_name_limit <= TagNameMax;
      cfg_q.key_name_limit <= KeyNameMax;
      cfg_q.value_limit    <= PropValueMax;
      cfg_q.property_limit <= PropertyMax;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

[hw/rtl/btt_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Tag parser
// Input register, parser state and the combinational step that yields up to
// two events per item.
// ----------------------------------------------------------------------------
module btt_parser import btt_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  cfg_t            cfg_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_eod_i,
  input  wire logic       space_ok_i,
  output logic [1:0]      push_n_o,
  output res_t            res0_o,
  output res_t            res1_o
);

  localparam logic [2:0] ModeOutside = 3'd0;
  localparam logic [2:0] ModeName    = 3'd1;
  localparam logic [2:0] ModeKey     = 3'd2;
  localparam logic [2:0] ModeQuote   = 3'd3;
  localparam logic [2:0] ModeValue   = 3'd4;
  localparam logic [2:0] ModeError   = 3'd5;

  localparam logic [7:0] ChLBracket = 8'h5B;
  localparam logic [7:0] ChRBracket = 8'h5D;
  localparam logic [7:0] ChEquals   = 8'h3D;
  localparam logic [7:0] ChQuote    = 8'h22;
  localparam logic [7:0] ChBslash   = 8'h5C;
  localparam logic [7:0] ChLowerN   = 8'h6E;
  localparam logic [7:0] ChNl       = 8'h0A;
  localparam logic [7:0] ChCr       = 8'h0D;
  localparam logic [7:0] ChTab      = 8'h09;
  localparam logic [7:0] ChSpace    = 8'h20;
  localparam logic [7:0] ChDash     = 8'h2D;
  localparam logic [7:0] ChUscore   = 8'h5F;

  localparam logic [LineW-1:0] LineTop = {LineW{1'b1}};

  logic             in_valid_q;
  logic [7:0]       byte_q;
  logic             eod_q;
  logic             proc;

  logic [2:0]         mode_q, mode_d;
  logic [ValLenW-1:0] run_q, run_d;
  logic [7:0]         prop_q, prop_d;
  logic [LineW-1:0]   line_q, line_d, line_inc;
  logic               esc_q, esc_d;

  logic [1:0] n;
  res_t       r0, r1;
  logic       blank, key_char, val_full, val_full2;
  logic [7:0] c;

  function automatic res_t mk_res(logic [2:0] kind, logic [7:0] b, logic [7:0] slot,
                                  logic [7:0] total, logic [2:0] code,
                                  logic [LineW-1:0] line);
    res_t r;
    r.event_kind  = kind;
    r.byte_out    = b;
    r.prop_slot   = slot;
    r.prop_total  = total;
    r.line_no     = line;
    r.error_code  = code;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  assign proc       = in_valid_q & space_ok_i;
  assign in_ready_o = ~in_valid_q | space_ok_i;

  assign c         = byte_q;
  assign blank     = (c == ChSpace) || (c == ChCr) || (c == ChTab) || (c == ChNl);
  assign key_char  = (c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]}) ||
                     (c == ChDash) || (c == ChUscore);
  assign val_full  = run_q >= cfg_i.value_limit;
  assign val_full2 = (run_q + 16'd1) >= cfg_i.value_limit;
  assign line_inc  = (line_q != LineTop) ? line_q + 24'd1 : line_q;

  always_comb begin
    mode_d = mode_q;
    run_d  = run_q;
    prop_d = prop_q;
    line_d = line_q;
    esc_d  = esc_q;
    n      = 2'd0;
    r0     = mk_res(EvName, 8'd0, 8'd0, 8'd0, ErChar, line_q);
    r1     = r0;
    if (eod_q) begin
      if (esc_q) begin
        if (val_full) begin
          r0 = mk_res(EvError, 8'd0, 8'd0, 8'd0, ErValue, line_q);
          n  = 2'd1;
        end else begin
          r0 = mk_res(EvValue, ChBslash, prop_q, 8'd0, ErChar, line_q);
          r1 = mk_res(EvError, 8'd0, 8'd0, 8'd0, ErEof, line_q);
          n  = 2'd2;
        end
      end else if (mode_q == ModeOutside) begin
        r0 = mk_res(EvAccept, 8'd0, 8'd0, 8'd0, ErChar, line_q);
        n  = 2'd1;
      end else if (mode_q != ModeError) begin
        r0 = mk_res(EvError, 8'd0, 8'd0, 8'd0, ErEof, line_q);
        n  = 2'd1;
      end
      mode_d = ModeOutside;
      run_d  = '0;
      prop_d = '0;
      line_d = 24'd1;
      esc_d  = 1'b0;
    end else if (mode_q == ModeError) begin
      n = 2'd0;
    end else if (esc_q) begin
      esc_d = 1'b0;
      if (val_full) begin
        mode_d = ModeError;
        r0     = mk_res(EvError, 8'd0, 8'd0, 8'd0, ErValue, line_q);
        n      = 2'd1;
      end else if ((c == ChQuote) || (c == ChBslash) || (c == ChLowerN)) begin
        r0    = mk_res(EvValue, (c == ChLowerN) ? ChNl : c, prop_q, 8'd0, ErChar, line_q);
        run_d = run_q + 16'd1;
        n     = 2'd1;
      end else begin
        r0 = mk_res(EvValue, ChBslash, prop_q, 8'd0, ErChar, line_q);
        n  = 2'd2;
        if (val_full2) begin
          mode_d = ModeError;
          run_d  = run_q + 16'd1;
          r1     = mk_res(EvError, 8'd0, 8'd0, 8'd0, ErValue, line_q);
        end else begin
          run_d = run_q + 16'd2;
          r1    = mk_res(EvValue, c, prop_q, 8'd0, ErChar, line_q);
        end
      end
    end else begin
      case (mode_q)
        ModeOutside: begin
          if (c == ChLBracket) begin
            mode_d = ModeName;
            run_d  = '0;
            prop_d = '0;
          end else if (c == ChNl) begin
            line_d = line_inc;
          end else if (!blank) begin
            mode_d = ModeError;
            r0     = mk_res(EvError, 8'd0, 8'd0, 8'd0, ErChar, line_q);
            n      = 2'd1;
          end
        end
        ModeName: begin
          if (c == ChNl) begin
            line_d = line_inc;
          end
          if (blank) begin
            if (run_q != '0) begin
              mode_d = ModeKey;
              run_d  = '0;
            end
          end else if (c == ChRBracket) begin
            mode_d = ModeOutside;
            r0     = mk_res(EvTag, 8'd0, 8'd0, prop_q, ErChar, line_q);
            n      = 2'd1;
          end else if (run_q >= {8'd0, cfg_i.tag_name_limit}) begin
            mode_d = ModeError;
            r0     = mk_res(EvError, 8'd0, 8'd0, 8'd0, ErName, line_q);
            n      = 2'd1;
          end else begin
            run_d = run_q + 16'd1;
            r0    = mk_res(EvName, c, 8'd0, 8'd0, ErChar, line_q);
            n     = 2'd1;
          end
        end
        ModeKey: begin
          if ((run_q == '0) && (c == ChRBracket)) begin
            mode_d = ModeOutside;
            r0     = mk_res(EvTag, 8'd0, 8'd0, prop_q, ErChar, line_q);
            n      = 2'd1;
          end else if ((run_q == '0) && blank) begin
            if (c == ChNl) begin
              line_d = line_inc;
            end
          end else if ((run_q == '0) && (prop_q >= cfg_i.property_limit)) begin
            mode_d = ModeError;
            r0     = mk_res(EvError, 8'd0, 8'd0, 8'd0, ErProps, line_q);
            n      = 2'd1;
          end else if ((run_q != '0) && (c == ChEquals)) begin
            mode_d = ModeQuote;
            run_d  = '0;
          end else if (run_q >= {8'd0, cfg_i.key_name_limit}) begin
            mode_d = ModeError;
            r0     = mk_res(EvError, 8'd0, 8'd0, 8'd0, ErKey, line_q);
            n      = 2'd1;
          end else if (!key_char) begin
            mode_d = ModeError;
            r0     = mk_res(EvError, 8'd0, 8'd0, 8'd0, ErChar, line_q);
            n      = 2'd1;
          end else begin
            run_d = run_q + 16'd1;
            r0    = mk_res(EvKey, c, prop_q, 8'd0, ErChar, line_q);
            n     = 2'd1;
          end
        end
        ModeQuote: begin
          if (blank) begin
            if (c == ChNl) begin
              line_d = line_inc;
            end
          end else if (c == ChQuote) begin
            mode_d = ModeValue;
            run_d  = '0;
          end else begin
            mode_d = ModeError;
            r0     = mk_res(EvError, 8'd0, 8'd0, 8'd0, ErChar, line_q);
            n      = 2'd1;
          end
        end
        ModeValue: begin
          if (c == ChBslash) begin
            esc_d = 1'b1;
          end else if (c == ChQuote) begin
            r0     = mk_res(EvProp, 8'd0, prop_q, 8'd0, ErChar, line_q);
            n      = 2'd1;
            prop_d = (prop_q != 8'hFF) ? prop_q + 8'd1 : prop_q;
            mode_d = ModeKey;
            run_d  = '0;
          end else if (val_full) begin
            mode_d = ModeError;
            r0     = mk_res(EvError, 8'd0, 8'd0, 8'd0, ErValue, line_q);
            n      = 2'd1;
          end else begin
            run_d = run_q + 16'd1;
            r0    = mk_res(EvValue, c, prop_q, 8'd0, ErChar, line_q);
            n     = 2'd1;
          end
        end
        default: begin
          n = 2'd0;
        end
      endcase
    end
    r0.last_of_run = (n == 2'd1);
    r1.last_of_run = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (proc) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
      eod_q  <= in_eod_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeOutside;
      run_q  <= '0;
      prop_q <= '0;
      line_q <= 24'd1;
      esc_q  <= 1'b0;
    end else if (proc) begin
      mode_q <= mode_d;
      run_q  <= run_d;
      prop_q <= prop_d;
      line_q <= line_d;
      esc_q  <= esc_d;
    end
  end

  assign push_n_o = proc ? n : 2'd0;
  assign res0_o   = r0;
  assign res1_o   = r1;

endmodule
`default_nettype wire

[hw/rtl/btt_res_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Event queue
// Three-entry queue that takes up to two events per cycle and gives one per cycle while the output is ready.
// ----------------------------------------------------------------------------
module btt_res_fifo import btt_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [1:0] push_n_i,
  input  res_t            d0_i,
  input  res_t            d1_i,
  output logic            space_ok_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output res_t            out_data_o
);

  localparam logic [FifoPtrW-1:0] LastPtr = FifoPtrW'(FifoDepth - 1);

  res_t                mem [FifoDepth];
  logic [FifoPtrW-1:0] wp_q, wp_d, rp_q, rp_d, wp_nx;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic                pop;

  function automatic logic [FifoPtrW-1:0] ptr_inc(logic [FifoPtrW-1:0] p);
    return (p == LastPtr) ? '0 : p + 1'b1;
  endfunction

  assign pop    = out_valid_o & out_ready_i;
  assign wp_nx  = ptr_inc(wp_q);
  assign wp_d   = (push_n_i == 2'd0) ? wp_q : (push_n_i == 2'd1) ? wp_nx : ptr_inc(wp_nx);
  assign rp_d   = pop ? ptr_inc(rp_q) : rp_q;
  assign cnt_d  = cnt_q + FifoCntW'(push_n_i) - FifoCntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem[wp_q] <= d0_i;
    end
    if (push_n_i == 2'd2) begin
      mem[wp_nx] <= d1_i;
    end
  end

  assign space_ok_o  = cnt_q <= FifoCntW'(FifoDepth - 2);
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem[rp_q];

endmodule
`default_nettype wire

[hw/rtl/bracket_tag_tokenizer.sv]
// An accepted item is held in the input register, and its events are written into the event
// queue, whose head is presented on the output. Throughput: one item per cycle while the
// output is ready; an item that yields two events (escape cases) holds up the next item.
// The event queue of three entries parts the output from the parser step.
// Reset clears parser state and queue and sets the limit registers to their defaults;
// an end-of-document item returns the parser state to reset but keeps the limits.
`default_nettype none
// ----------------------------------------------------------------------------
// Bracket tag tokenizer
// Tokenizes a byte stream of bracketed tags into name, key, value and status
// events, with limit checks and a configuration write port.
// ----------------------------------------------------------------------------
module bracket_tag_tokenizer import btt_pkg::*; (
  input wire logic    clk_i,
  input wire logic    rst_ni,
  btt_doc_if.sink     doc_i,
  btt_evt_if.source   evt_o,
  btt_cfg_if.sink     cfg_i
);

  cfg_t       cfg;
  logic       space_ok;
  logic [1:0] push_n;
  res_t       res0, res1, head;

  assign cfg_i.ready = 1'b1;

  btt_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  btt_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (doc_i.valid),
    .in_ready_o (doc_i.ready),
    .in_byte_i  (doc_i.byte_in),
    .in_eod_i   (doc_i.end_of_doc),
    .space_ok_i (space_ok),
    .push_n_o   (push_n),
    .res0_o     (res0),
    .res1_o     (res1)
  );

  btt_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (push_n),
    .d0_i        (res0),
    .d1_i        (res1),
    .space_ok_o  (space_ok),
    .out_valid_o (evt_o.valid),
    .out_ready_i (evt_o.ready),
    .out_data_o  (head)
  );

  assign evt_o.event_kind  = head.event_kind;
  assign evt_o.byte_out    = head.byte_out;
  assign evt_o.prop_slot   = head.prop_slot;
  assign evt_o.prop_total  = head.prop_total;
  assign evt_o.line_no     = head.line_no;
  assign evt_o.error_code  = head.error_code;
  assign evt_o.last_of_run = head.last_of_run;

endmodule
`default_nettype wire
